// ----- sv/grra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package grra_pkg;

    localparam int ACT_W = 3;

    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NEG = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CMP = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [ACT_W-1:0] action;
        logic             equal;
    } ctl_t;

endpackage

`default_nettype wire

// ----- sv/grra_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module grra_mul #(
    parameter int COEFF_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic signed [COEFF_WIDTH-1:0]  a,
    input  wire logic signed [COEFF_WIDTH-1:0]  b,
    output logic signed [2*COEFF_WIDTH-1:0]     p
);

    localparam int W    = COEFF_WIDTH;
    localparam int LO_W = W / 2;
    localparam int HI_W = W - LO_W;
    localparam int PW   = 2 * W;

    logic signed [HI_W-1:0]      a_hi;
    logic signed [HI_W-1:0]      b_hi;
    logic        [LO_W-1:0]      a_lo;
    logic        [LO_W-1:0]      b_lo;

    logic signed [2*HI_W-1:0]    hh_next;
    logic signed [2*HI_W-1:0]    hh_reg;
    logic signed [HI_W+LO_W:0]   hl_next;
    logic signed [HI_W+LO_W:0]   hl_reg;
    logic signed [HI_W+LO_W:0]   lh_next;
    logic signed [HI_W+LO_W:0]   lh_reg;
    logic        [2*LO_W-1:0]    ll_next;
    logic        [2*LO_W-1:0]    ll_reg;
    logic signed [PW-1:0]        p_next;
    logic signed [PW-1:0]        p_reg;

    assign a_hi = a[W-1:LO_W];
    assign b_hi = b[W-1:LO_W];
    assign a_lo = a[LO_W-1:0];
    assign b_lo = b[LO_W-1:0];

    always_comb begin
        hh_next = a_hi * b_hi;
        hl_next = a_hi * $signed({1'b0, b_lo});
        lh_next = $signed({1'b0, a_lo}) * b_hi;
        ll_next = a_lo * b_lo;
    end

    always_comb begin
        p_next = (PW'(hh_reg) <<< (2 * LO_W))
               + ((PW'(hl_reg) + PW'(lh_reg)) <<< LO_W)
               + PW'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- sv/grra_reduce.sv -----
`timescale 1ns / 1ps
`default_nettype none

module grra_reduce #(
    parameter int COEFF_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire grra_pkg::ctl_t                    ctl_in,
    input  wire logic signed [COEFF_WIDTH:0]       lin_in [4],
    input  wire logic signed [2*COEFF_WIDTH-1:0]   prod [16],
    output grra_pkg::ctl_t                         ctl_out,
    output logic signed [2*COEFF_WIDTH+2:0]        exact [4]
);

    import grra_pkg::*;

    localparam int W  = COEFF_WIDTH;
    localparam int EW = 2 * W + 3;

    ctl_t                  ctl3_reg;
    ctl_t                  ctl4_reg;
    logic signed [W:0]     lin3_reg [4];
    logic signed [EW-1:0]  term_next [4][4];
    logic signed [EW-1:0]  term_reg  [4][4];
    logic signed [EW-1:0]  exact_next [4];
    logic signed [EW-1:0]  exact_reg  [4];

    // products: index 4*i+j for left {a,b,c,d}[i] times right {x,y,z,w}[j]
    always_comb begin
        term_next[0][0] = EW'(prod[0])  + EW'(prod[7]);
        term_next[0][1] = EW'(prod[10]) + EW'(prod[13]);
        term_next[0][2] = EW'(prod[15]);
        term_next[0][3] = '0;

        term_next[1][0] = EW'(prod[1])  + EW'(prod[4]);
        term_next[1][1] = EW'(prod[11]) + EW'(prod[14]);
        term_next[1][2] = '0;
        term_next[1][3] = '0;

        term_next[2][0] = EW'(prod[2])  + EW'(prod[5]);
        term_next[2][1] = EW'(prod[8])  + EW'(prod[7]);
        term_next[2][2] = EW'(prod[10]) + EW'(prod[13]);
        term_next[2][3] = EW'(prod[15]) <<< 1;

        term_next[3][0] = EW'(prod[3])  + EW'(prod[6]);
        term_next[3][1] = EW'(prod[9])  + EW'(prod[12]);
        term_next[3][2] = EW'(prod[11]) + EW'(prod[14]);
        term_next[3][3] = '0;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (ctl3_reg.action == ACT_MUL) begin
                exact_next[i] = term_reg[i][0] + term_reg[i][1]
                              + term_reg[i][2] + term_reg[i][3];
            end else begin
                exact_next[i] = EW'(lin3_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end else if (en) begin
            ctl3_reg <= ctl_in;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lin3_reg  <= lin_in;
            term_reg  <= term_next;
            exact_reg <= exact_next;
        end
    end

    assign ctl_out = ctl4_reg;
    assign exact   = exact_reg;

endmodule

`default_nettype wire

// ----- sv/golden_root_ring_alu_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Exact ring arithmetic on a + b*s + c*phi + d*s*phi with s = sqrt(phi): add, subtract,
// multiply, negate left and compare equal. The block is a five-stage pipeline that takes
// one item every clock unless the output stalls. Multiply runs sixteen coefficient
// products in parallel, each split into half-width partial products (stages one and
// two), then adds them in two steps (stages three and four); stage five wraps each
// coefficient to COEFF_WIDTH and flags overflow, or for compare passes the equal flag.
// The whole pipeline holds while the output item waits on m_tready, so s_tready
// follows m_tready whenever an output item is pending.
module golden_root_ring_alu_top #(
    parameter int COEFF_WIDTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // left_one, left_root, left_phi, left_root_phi,
    // right_one, right_root, right_phi, right_root_phi
    input  wire logic [8*COEFF_WIDTH-1:0]              s_tdata,
    // action
    input  wire logic [grra_pkg::ACT_W-1:0]            s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // out_one, out_root, out_phi, out_root_phi, zero fill
    output logic [((4*COEFF_WIDTH+7)/8)*8-1:0]         m_tdata,
    // equal_flag, overflow_flag
    output logic [1:0]                                 m_tuser
);

    import grra_pkg::*;

    localparam int W      = COEFF_WIDTH;
    localparam int PW     = 2 * W;
    localparam int EW     = 2 * W + 3;
    localparam int LW     = W + 1;
    localparam int OUT_DW = ((4 * W + 7) / 8) * 8;

    logic                  en;
    logic signed [W-1:0]   left  [4];
    logic signed [W-1:0]   right [4];
    logic signed [PW-1:0]  prod  [16];

    ctl_t                  ctl1_next;
    ctl_t                  ctl1_reg;
    ctl_t                  ctl2_reg;
    ctl_t                  ctl4;
    logic signed [LW-1:0]  lin1_next [4];
    logic signed [LW-1:0]  lin1_reg  [4];
    logic signed [LW-1:0]  lin2_reg  [4];
    logic signed [EW-1:0]  exact [4];

    logic                  m_tvalid_reg;
    logic [OUT_DW-1:0]     m_tdata_next;
    logic [OUT_DW-1:0]     m_tdata_reg;
    logic [1:0]            m_tuser_next;
    logic [1:0]            m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            left[i]  = s_tdata[i*W +: W];
            right[i] = s_tdata[(i+4)*W +: W];
        end
    end

    for (genvar gi = 0; gi < 4; gi++) begin : g_row
        for (genvar gj = 0; gj < 4; gj++) begin : g_col
            grra_mul #(
                .COEFF_WIDTH (COEFF_WIDTH)
            ) u_mul (
                .aclk (aclk),
                .en   (en),
                .a    (left[gi]),
                .b    (right[gj]),
                .p    (prod[4*gi+gj])
            );
        end
    end

    always_comb begin
        ctl1_next.valid  = s_tvalid;
        ctl1_next.action = s_tuser;
        ctl1_next.equal  = (left[0] == right[0]) && (left[1] == right[1])
                        && (left[2] == right[2]) && (left[3] == right[3]);
        for (int i = 0; i < 4; i++) begin
            case (s_tuser)
                ACT_ADD: lin1_next[i] = LW'(left[i]) + LW'(right[i]);
                ACT_SUB: lin1_next[i] = LW'(left[i]) - LW'(right[i]);
                ACT_NEG: lin1_next[i] = -LW'(left[i]);
                default: lin1_next[i] = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (en) begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lin1_reg <= lin1_next;
            lin2_reg <= lin1_reg;
        end
    end

    grra_reduce #(
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (ctl2_reg),
        .lin_in  (lin2_reg),
        .prod    (prod),
        .ctl_out (ctl4),
        .exact   (exact)
    );

    always_comb begin
        m_tdata_next = '0;
        m_tuser_next = '0;
        case (ctl4.action)
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_NEG: begin
                for (int i = 0; i < 4; i++) begin
                    m_tdata_next[i*W +: W] = exact[i][W-1:0];
                    if (!((&exact[i][EW-1:W-1]) || !(|exact[i][EW-1:W-1]))) begin
                        m_tuser_next[1] = 1'b1;
                    end
                end
            end
            ACT_CMP: m_tuser_next[0] = ctl4.equal;
            default: m_tuser_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ctl4.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ctl1_reg.valid)
        else $error("accepted item missing from first stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(ctl1_reg) && $stable(m_tdata) && $stable(m_tuser))
        else $error("pipeline moved during output stall");

    a_compare_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("compare result carries nonzero coefficients");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("equal and overflow flags both set");

endmodule

`default_nettype wire

// ----- tb/sv/golden_root_ring_alu_top_tb.sv -----
`timescale 1ns / 1ps

module golden_root_ring_alu_top_tb;

    import grra_pkg::*;

    localparam int CW          = 32;
    localparam int WIDE        = 2 * CW + 8;
    localparam int LIMIT       = 1000000;
    localparam int DRAIN       = 20;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLDOFF_CYCLES = 300;

    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

    localparam logic [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] C_ZERO = '0;
    localparam logic [CW-1:0] C_ONE  = 1;
    localparam logic [CW-1:0] C_NEG1 = '1;

    typedef struct packed {
        logic [ACT_W-1:0]     act;
        logic [3:0][CW-1:0]   lhs;
        logic [3:0][CW-1:0]   rhs;
    } ring_op_t;

    typedef struct packed {
        logic [3:0][CW-1:0]   coeff;
        logic                 equal;
        logic                 overflow;
    } ring_result_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    wire logic                        s_tready;
    logic [8*CW-1:0]                  s_tdata  = '0;
    logic [ACT_W-1:0]                 s_tuser  = '0;
    wire logic                        m_tvalid;
    logic                             m_tready = 1'b0;
    wire logic [((4*CW+7)/8)*8-1:0]   m_tdata;
    wire logic [1:0]                  m_tuser;

    ring_result_t ring_expect_q[$];
    ring_result_t want_r;
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           holdoff_left   = 0;
    int           rx_wait        = 0;
    bit           idle_on        = 1'b1;
    bit           hold_req       = 1'b0;
    bit           hold_ack       = 1'b0;
    string        coeff_name[4]  = '{"out_one", "out_root", "out_phi", "out_root_phi"};

    golden_root_ring_alu_top #(
        .COEFF_WIDTH(CW)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic ring_result_t ring_compute(ring_op_t op);
        logic signed [WIDE-1:0] exact[4];
        logic signed [WIDE-1:0] fitted;
        logic signed [WIDE-1:0] a, b, c, d, x, y, z, w;
        ring_result_t res;
        res = '0;
        a = $signed(op.lhs[0]);
        b = $signed(op.lhs[1]);
        c = $signed(op.lhs[2]);
        d = $signed(op.lhs[3]);
        x = $signed(op.rhs[0]);
        y = $signed(op.rhs[1]);
        z = $signed(op.rhs[2]);
        w = $signed(op.rhs[3]);
        for (int i = 0; i < 4; i++) exact[i] = '0;
        case (op.act)
            ACT_ADD: begin
                exact[0] = a + x;
                exact[1] = b + y;
                exact[2] = c + z;
                exact[3] = d + w;
            end
            ACT_SUB: begin
                exact[0] = a - x;
                exact[1] = b - y;
                exact[2] = c - z;
                exact[3] = d - w;
            end
            ACT_MUL: begin
                exact[0] = a * x + b * w + c * z + d * y + d * w;
                exact[1] = a * y + b * x + c * w + d * z;
                exact[2] = a * z + b * y + c * x + b * w + c * z + d * y + d * w + d * w;
                exact[3] = a * w + b * z + c * y + d * x + c * w + d * z;
            end
            ACT_NEG: begin
                exact[0] = -a;
                exact[1] = -b;
                exact[2] = -c;
                exact[3] = -d;
            end
            ACT_CMP: res.equal = (op.lhs == op.rhs);
            default: ;
        endcase
        for (int i = 0; i < 4; i++) begin
            res.coeff[i] = exact[i][CW-1:0];
            fitted = $signed(exact[i][CW-1:0]);
            if (fitted != exact[i]) res.overflow = 1'b1;
        end
        return res;
    endfunction

    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CW-1:0] rand_coeff();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return C_ZERO;
                    3: return C_ONE;
                    default: return C_NEG1;
                endcase
            end
            1, 2, 3: return CW'($urandom_range(0, 32) - 16);
            4: return CW'($urandom_range(0, 65535)) - CW'(32768);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic ring_op_t make_op(logic [ACT_W-1:0] act,
                                         logic [CW-1:0] a, logic [CW-1:0] b,
                                         logic [CW-1:0] c, logic [CW-1:0] d,
                                         logic [CW-1:0] x, logic [CW-1:0] y,
                                         logic [CW-1:0] z, logic [CW-1:0] w);
        ring_op_t op;
        op.act = act;
        op.lhs = {d, c, b, a};
        op.rhs = {w, z, y, x};
        return op;
    endfunction

    function automatic ring_op_t rand_op();
        ring_op_t op;
        int unsigned k;
        for (int i = 0; i < 4; i++) begin
            op.lhs[i] = rand_coeff();
            op.rhs[i] = rand_coeff();
        end
        if ($urandom_range(0, 99) < 96) op.act = ACT_W'($urandom_range(ACT_ADD, ACT_CMP));
        else op.act = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        if (op.act == ACT_CMP) begin
            k = $urandom_range(0, 3);
            if (k < 2) begin
                op.rhs = op.lhs;
            end else if (k == 2) begin
                op.rhs = op.lhs;
                k = $urandom_range(0, 3);
                op.rhs[k] = op.rhs[k] ^ (CW'(1) << $urandom_range(0, CW - 1));
            end
        end
        return op;
    endfunction

    task automatic send_item(ring_op_t op);
        int unsigned gap;
        gap = idle_on ? pick_pause() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {op.rhs, op.lhs};
        s_tuser  <= op.act;
        do @(posedge aclk); while (!s_tready);
        ring_expect_q.push_back(ring_compute(op));
    endtask

    task automatic report_field(string field, logic [CW-1:0] want, logic [CW-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (ring_expect_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item expected none actual %h / %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want_r = ring_expect_q.pop_front();
                for (int i = 0; i < 4; i++)
                    report_field(coeff_name[i], want_r.coeff[i], m_tdata[i*CW +: CW]);
                report_field("equal_flag", CW'(want_r.equal), CW'(m_tuser[0]));
                report_field("overflow_flag", CW'(want_r.overflow), CW'(m_tuser[1]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            m_tready     <= 1'b0;
            hold_ack     <= hold_req;
            holdoff_left <= HOLDOFF_CYCLES;
        end else if (holdoff_left != 0) begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (rx_wait != 0) begin
            m_tready <= 1'b0;
            rx_wait  <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) rx_wait <= pick_pause();
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_add_sub_extremes();
        send_item(make_op(ACT_ADD, C_MAX, C_MAX, C_MIN, C_ZERO, C_MAX, C_ONE, C_MIN, C_ZERO));
        send_item(make_op(ACT_ADD, C_MIN, C_MAX, C_NEG1, C_ONE, C_MAX, C_MIN, C_ONE, C_NEG1));
        send_item(make_op(ACT_SUB, C_MIN, C_MAX, C_ZERO, C_NEG1, C_ONE, C_NEG1, C_MIN, C_MAX));
        send_item(make_op(ACT_SUB, C_ZERO, C_ONE, C_MAX, C_MIN, C_ZERO, C_ONE, C_MAX, C_MIN));
    endtask

    task automatic test_multiply();
        send_item(make_op(ACT_MUL, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE));
        send_item(make_op(ACT_MUL, C_ZERO, C_ONE, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO));
        send_item(make_op(ACT_MUL, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO));
        send_item(make_op(ACT_MUL, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO, C_ZERO, C_ONE));
        send_item(make_op(ACT_MUL, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_item(make_op(ACT_MUL, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_item(make_op(ACT_MUL, C_MIN, C_MAX, C_NEG1, C_MIN, C_MAX, C_MIN, C_MIN, C_NEG1));
        send_item(make_op(ACT_MUL, 3, -2, 5, -7, -4, 6, -1, 2));
    endtask

    task automatic test_negate();
        send_item(make_op(ACT_NEG, C_MIN, C_MAX, C_ZERO, C_NEG1, rand_coeff(), rand_coeff(),
                          rand_coeff(), rand_coeff()));
        send_item(make_op(ACT_NEG, C_ONE, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX));
    endtask

    task automatic test_compare();
        send_item(make_op(ACT_CMP, C_MIN, C_MAX, C_NEG1, C_ZERO, C_MIN, C_MAX, C_NEG1, C_ZERO));
        send_item(make_op(ACT_CMP, C_MIN, C_MAX, C_NEG1, C_ZERO, C_MIN, C_MAX, C_NEG1, C_ONE));
        send_item(make_op(ACT_CMP, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                          C_ZERO));
        send_item(make_op(ACT_CMP, C_MAX, C_ONE, C_ONE, C_ONE, C_MIN, C_ONE, C_ONE, C_ONE));
    endtask

    task automatic test_spare_codes();
        ring_op_t op;
        for (int code = ACT_SPARE_FIRST; code <= ACT_SPARE_LAST; code++) begin
            op = rand_op();
            op.act = ACT_W'(code);
            send_item(op);
        end
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_req = ~hold_req;
        for (int n = 0; n < 40; n++) send_item(rand_op());
        idle_on = 1'b1;
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 250 == 0) idle_on = ((n / 250) % 4 != 3);
            send_item(rand_op());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_add_sub_extremes();
        test_multiply();
        test_negate();
        test_compare();
        test_spare_codes();
        test_backpressure();
        test_random_stream();
        s_tvalid <= 1'b0;
        while (ring_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
